### rtl/mwcrbg_pkg.sv
// shared types, constants and helpers for the multiply-with-carry byte generator
package mwcrbg_pkg;

	localparam int WORD_W = 32;
	localparam int HALF_W = 16;
	localparam int BYTE_W = 8;
	localparam int CNT_BITS = $clog2(WORD_W);
	localparam int PERIOD_W = 8;

	localparam logic [HALF_W-1:0] MWC_Z_MUL = 16'd36969;
	localparam logic [HALF_W-1:0] MWC_W_MUL = 16'd18000;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd67;

	// controls from the sequencer to the generator words
	typedef struct packed {
		logic load;
		logic adv;
	} gen_ctl_t;

	// status of the remainder unit
	typedef struct packed {
		logic busy;
		logic done;
	} rem_stat_t;

	// xor all four bytes of a word together
	function automatic logic [BYTE_W-1:0] fold_bytes(input logic [WORD_W-1:0] x);
		fold_bytes = x[31:24] ^ x[23:16] ^ x[15:8] ^ x[7:0];
	endfunction

endpackage

### rtl/mwcrbg_gen.sv
// two multiply-with-carry words and the byte folded from their next values
module mwcrbg_gen (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mwcrbg_pkg::gen_ctl_t               ctl,
	input  logic [mwcrbg_pkg::WORD_W-1:0]      seed_z,
	input  logic [mwcrbg_pkg::WORD_W-1:0]      seed_w,
	output logic [mwcrbg_pkg::BYTE_W-1:0]      byte_nxt
);

	logic [mwcrbg_pkg::WORD_W-1:0] z_q;
	logic [mwcrbg_pkg::WORD_W-1:0] w_q;
	logic [mwcrbg_pkg::WORD_W-1:0] z_nxt;
	logic [mwcrbg_pkg::WORD_W-1:0] w_nxt;

	always_comb begin
		z_nxt = mwcrbg_pkg::MWC_Z_MUL * z_q[mwcrbg_pkg::HALF_W-1:0]
			+ {{mwcrbg_pkg::HALF_W{1'b0}}, z_q[mwcrbg_pkg::WORD_W-1:mwcrbg_pkg::HALF_W]};
		w_nxt = mwcrbg_pkg::MWC_W_MUL * w_q[mwcrbg_pkg::HALF_W-1:0]
			+ {{mwcrbg_pkg::HALF_W{1'b0}}, w_q[mwcrbg_pkg::WORD_W-1:mwcrbg_pkg::HALF_W]};
	end

	assign byte_nxt = mwcrbg_pkg::fold_bytes(z_nxt ^ w_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_q <= '0;
			w_q <= '0;
		end else if (ctl.load) begin
			z_q <= seed_z;
			w_q <= seed_w;
		end else if (ctl.adv) begin
			z_q <= z_nxt;
			w_q <= w_nxt;
		end
	end

endmodule

### rtl/mwcrbg_rem.sv
// restoring remainder unit, one dividend bit per cycle
module mwcrbg_rem (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [mwcrbg_pkg::WORD_W-1:0]      dividend,
	input  logic [mwcrbg_pkg::WORD_W-1:0]      divisor,
	output logic [mwcrbg_pkg::WORD_W-1:0]      remainder,
	output mwcrbg_pkg::rem_stat_t              stat
);

	logic                              busy_q;
	logic                              done_q;
	logic [mwcrbg_pkg::CNT_BITS-1:0]   cnt_q;
	logic [mwcrbg_pkg::WORD_W-1:0]     r_q;
	logic [mwcrbg_pkg::WORD_W-1:0]     d_q;
	logic [mwcrbg_pkg::WORD_W-1:0]     div_q;
	logic [mwcrbg_pkg::WORD_W:0]       trial;
	logic [mwcrbg_pkg::WORD_W-1:0]     r_nxt;

	// a zero divisor always subtracts nothing, leaving the dividend
	always_comb begin
		trial = {r_q, d_q[mwcrbg_pkg::WORD_W-1]};
		if (trial >= {1'b0, div_q}) begin
			r_nxt = mwcrbg_pkg::WORD_W'(trial - {1'b0, div_q});
		end else begin
			r_nxt = trial[mwcrbg_pkg::WORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == {mwcrbg_pkg::CNT_BITS{1'b1}});
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {mwcrbg_pkg::CNT_BITS{1'b1}}) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= '0;
			d_q   <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			r_q <= r_nxt;
			d_q <= {d_q[mwcrbg_pkg::WORD_W-2:0], 1'b0};
		end
	end

	assign remainder = r_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### rtl/mwc_random_byte_generator_top.sv
// top level: request sequencer, reseed counter and output register
//
//   channel   signals                                    direction
//   input     in_valid/in_ready, req_type, byte_count,   in
//             bound, seed_w, seed_z
//   output    out_valid/out_ready, data, last            out
//   config    cfg_we, cfg_wdata (reseed period)          in
//
// byte run: after the accept cycle, one word per cycle while the output is not stalled
// bounded word: accept, 4 byte steps, start, 32 remainder steps, done, load
// the 32 steps come from the bit-serial remainder unit
// a new request is taken in the idle state even while the last word still waits
// output stalls hold the byte sequencer; reset clears words and counter, loads PERIOD_RESET as period
module mwc_random_byte_generator_top #(
	parameter int MAX_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [6:0]  byte_count,
	input  logic [31:0] bound,
	input  logic [31:0] seed_w,
	input  logic [31:0] seed_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] data,
	output logic        last,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	localparam int CNT_W = $clog2(MAX_BYTES + 1);
	localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BYTES,
		ST_PACK,
		ST_DIV,
		ST_RES
	} state_t;

	state_t                              state_q;
	logic [mwcrbg_pkg::PERIOD_W-1:0]     period_q;
	logic [mwcrbg_pkg::PERIOD_W-1:0]     req_cnt_q;
	logic [CNT_W-1:0]                    rem_cnt_q;
	logic [1:0]                          pk_cnt_q;
	logic                                start_q;
	logic [mwcrbg_pkg::WORD_W-1:0]       word_q;
	logic [mwcrbg_pkg::WORD_W-1:0]       bound_q;
	logic                                out_valid_q;
	logic [mwcrbg_pkg::WORD_W-1:0]       data_q;
	logic                                last_q;

	logic                                in_acc;
	logic                                slot_free;
	logic                                out_load;
	logic [mwcrbg_pkg::PERIOD_W:0]       req_nxt;
	logic [CMP_W-1:0]                    bc_ext;
	logic [CNT_W-1:0]                    count_eff;
	logic [mwcrbg_pkg::BYTE_W-1:0]       byte_nxt;
	logic [mwcrbg_pkg::WORD_W-1:0]       rem_val;
	mwcrbg_pkg::gen_ctl_t                gen_ctl;
	mwcrbg_pkg::rem_stat_t               rem_st;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_load  = slot_free && ((state_q == ST_BYTES) || (state_q == ST_RES));

	// clamp the run length to 1..MAX_BYTES
	always_comb begin
		bc_ext = CMP_W'(byte_count);
		if (bc_ext == '0) begin
			count_eff = CNT_W'(1);
		end else if (bc_ext > CMP_W'(MAX_BYTES)) begin
			count_eff = CNT_W'(MAX_BYTES);
		end else begin
			count_eff = CNT_W'(bc_ext);
		end
	end

	// a period of zero wraps every time, the same as one
	always_comb begin
		req_nxt = {1'b0, req_cnt_q} + 1'b1;
		if (req_nxt >= {1'b0, period_q}) begin
			req_nxt = '0;
		end
	end

	assign gen_ctl.load = in_acc && (req_cnt_q == '0);
	assign gen_ctl.adv  = ((state_q == ST_BYTES) && slot_free) || (state_q == ST_PACK);

	mwcrbg_gen u_gen (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (gen_ctl),
		.seed_z   (seed_z),
		.seed_w   (seed_w),
		.byte_nxt (byte_nxt)
	);

	mwcrbg_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.dividend  (word_q),
		.divisor   (bound_q),
		.remainder (rem_val),
		.stat      (rem_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			period_q    <= mwcrbg_pkg::PERIOD_RESET;
			req_cnt_q   <= '0;
			rem_cnt_q   <= '0;
			pk_cnt_q    <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= (state_q == ST_PACK) && (pk_cnt_q == 2'd3);
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						req_cnt_q <= req_nxt[mwcrbg_pkg::PERIOD_W-1:0];
						rem_cnt_q <= count_eff;
						pk_cnt_q  <= '0;
						state_q   <= req_type ? ST_PACK : ST_BYTES;
					end
				end
				ST_BYTES: begin
					if (slot_free) begin
						rem_cnt_q <= rem_cnt_q - 1'b1;
						if (rem_cnt_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_PACK: begin
					pk_cnt_q <= pk_cnt_q + 1'b1;
					if (pk_cnt_q == 2'd3) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rem_st.done) begin
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			bound_q <= bound;
		end
		if (state_q == ST_PACK) begin
			// first byte ends up lowest
			word_q <= {byte_nxt, word_q[mwcrbg_pkg::WORD_W-1:mwcrbg_pkg::BYTE_W]};
		end
		if ((state_q == ST_BYTES) && slot_free) begin
			data_q <= {{(mwcrbg_pkg::WORD_W - mwcrbg_pkg::BYTE_W){1'b0}}, byte_nxt};
			last_q <= (rem_cnt_q == CNT_W'(1));
		end else if ((state_q == ST_RES) && slot_free) begin
			data_q <= rem_val;
			last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign data      = data_q;
	assign last      = last_q;

	a_rem_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		rem_st.done |-> (state_q == ST_DIV))
		else $error("remainder finished outside the divide state");

	a_run_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BYTES) |-> (rem_cnt_q != '0))
		else $error("byte run active with no bytes left");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != ST_IDLE))
		else $error("accepted request did not start");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |=> rem_st.busy)
		else $error("remainder unit did not start");

endmodule

### dv/mwc_random_byte_generator_top_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the multiply-with-carry random byte generator top level
module mwc_random_byte_generator_top_tb;

	localparam int MAX_BYTES = 64;
	localparam logic REQ_BYTES = 1'b0;
	localparam logic REQ_BOUNDED = 1'b1;
	localparam int IDLE_PCT = 34;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 50;
	localparam int RANDOM_ITEMS = 440;

	typedef struct packed {
		logic [mwcrbg_pkg::WORD_W-1:0] data;
		logic last;
	} rng_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = REQ_BYTES;
	logic [6:0] byte_count = '0;
	logic [31:0] bound = '0;
	logic [31:0] seed_w = '0;
	logic [31:0] seed_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] data;
	logic last;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;

	// generator words, request counter and period as the block should hold them
	logic [mwcrbg_pkg::WORD_W-1:0] z_word;
	logic [mwcrbg_pkg::WORD_W-1:0] w_word;
	logic [mwcrbg_pkg::PERIOD_W-1:0] req_count;
	logic [mwcrbg_pkg::PERIOD_W-1:0] period_reg;
	rng_word_t pending_words[$];

	bit steady_flow = 1'b0;
	int fail_count = 0;
	int n_requests = 0;
	int n_bounded = 0;
	int n_words = 0;
	int n_reseeds = 0;
	int n_periods = 0;
	int stall_cycles = 0;

	always #5 clk = ~clk;

	mwc_random_byte_generator_top #(
		.MAX_BYTES(MAX_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.byte_count(byte_count),
		.bound(bound),
		.seed_w(seed_w),
		.seed_z(seed_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data(data),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// step both multiply-with-carry words and xor their bytes together
	function automatic logic [mwcrbg_pkg::BYTE_W-1:0] advance_byte();
		logic [mwcrbg_pkg::WORD_W-1:0] x;
		z_word = mwcrbg_pkg::MWC_Z_MUL * z_word[mwcrbg_pkg::HALF_W-1:0]
			+ z_word[mwcrbg_pkg::WORD_W-1:mwcrbg_pkg::HALF_W];
		w_word = mwcrbg_pkg::MWC_W_MUL * w_word[mwcrbg_pkg::HALF_W-1:0]
			+ w_word[mwcrbg_pkg::WORD_W-1:mwcrbg_pkg::HALF_W];
		x = z_word ^ w_word;
		return x[31:24] ^ x[23:16] ^ x[15:8] ^ x[7:0];
	endfunction

	function automatic void gen_request_words(logic kind, logic [6:0] cnt, logic [31:0] lim,
			logic [31:0] sw, logic [31:0] sz);
		int n;
		int nxt;
		logic [mwcrbg_pkg::WORD_W-1:0] word_acc;
		rng_word_t w;
		if (req_count == 0) begin
			w_word = sw;
			z_word = sz;
			n_reseeds++;
		end
		nxt = int'(req_count) + 1;
		if (nxt >= int'(period_reg))
			nxt = 0;
		req_count = nxt[mwcrbg_pkg::PERIOD_W-1:0];
		if (kind == REQ_BYTES) begin
			n = (cnt == 0) ? 1 : (cnt > MAX_BYTES) ? MAX_BYTES : int'(cnt);
			for (int i = 0; i < n; i++) begin
				w.data = {24'd0, advance_byte()};
				w.last = (i == n - 1);
				pending_words.push_back(w);
			end
		end else begin
			word_acc = '0;
			// first byte lands in the low byte
			for (int i = 0; i < 4; i++)
				word_acc[8*i +: 8] = advance_byte();
			if (lim != 0)
				word_acc = word_acc % lim;
			w.data = word_acc;
			w.last = 1'b1;
			pending_words.push_back(w);
		end
	endfunction

	// starts and returns at a falling edge; valid is left high for the caller to reuse or drop
	task automatic send_req(logic kind, logic [6:0] cnt, logic [31:0] lim,
			logic [31:0] sw, logic [31:0] sz);
		while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		byte_count <= cnt;
		bound <= lim;
		seed_w <= sw;
		seed_z <= sz;
		do @(posedge clk); while (!in_ready);
		gen_request_words(kind, cnt, lim, sw, sz);
		n_requests++;
		if (kind == REQ_BOUNDED)
			n_bounded++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic write_period(logic [7:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		period_reg = value;
		n_periods++;
	endtask

	task automatic send_random_req();
		logic kind;
		logic [6:0] cnt;
		logic [31:0] lim;
		kind = 1'($urandom_range(1));
		case ($urandom_range(9))
			0: cnt = 7'($urandom_range(127));
			1, 2: cnt = 7'($urandom_range(64, 9));
			default: cnt = 7'($urandom_range(8, 1));
		endcase
		case ($urandom_range(9))
			0: lim = '0;
			1: lim = 32'd1 << $urandom_range(31);
			2, 3: lim = $urandom_range(255, 1);
			4: lim = 32'hFFFF_FFFF - $urandom_range(3);
			default: lim = $urandom();
		endcase
		send_req(kind, cnt, lim, $urandom(), $urandom());
	endtask

	task automatic test_byte_runs();
		send_req(REQ_BYTES, 7'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_req(REQ_BYTES, 7'd64, 32'd0, 32'h0, 32'h0);
		// zero count gives one byte, counts past the maximum are clipped
		send_req(REQ_BYTES, 7'd0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
		send_req(REQ_BYTES, 7'd65, 32'd0, 32'hFFFF_FFFF, 32'h0);
		send_req(REQ_BYTES, 7'd127, 32'd0, 32'h0, 32'h0);
		send_req(REQ_BYTES, 7'd2, 32'd0, 32'h0, 32'h0);
	endtask

	task automatic test_bounded_words();
		send_req(REQ_BOUNDED, 7'd0, 32'd1, 32'h0, 32'h0);
		send_req(REQ_BOUNDED, 7'd127, 32'hFFFF_FFFF, 32'h0, 32'h0);
		// zero bound passes the packed word through
		send_req(REQ_BOUNDED, 7'd64, 32'd0, 32'h0, 32'h0);
		send_req(REQ_BOUNDED, 7'd1, 32'h8000_0000, 32'h0, 32'h0);
		send_req(REQ_BOUNDED, 7'd3, 32'd7, 32'h0, 32'h0);
	endtask

	task automatic test_reseed_period();
		write_period(8'd1);
		send_req(REQ_BYTES, 7'd3, 32'd0, 32'h0, 32'h0);
		send_req(REQ_BOUNDED, 7'd0, 32'd1000, $urandom(), $urandom());
		write_period(8'd200);
		repeat (4) send_req(REQ_BYTES, 7'd2, 32'd0, $urandom(), $urandom());
		// counter now sits above the new period and must wrap
		write_period(8'd3);
		send_req(REQ_BYTES, 7'd4, 32'd0, $urandom(), $urandom());
		send_req(REQ_BOUNDED, 7'd0, $urandom(), $urandom(), $urandom());
		write_period(8'd0);
		send_req(REQ_BYTES, 7'd2, 32'd0, $urandom(), $urandom());
		send_req(REQ_BYTES, 7'd2, 32'd0, $urandom(), $urandom());
		write_period(8'd255);
		send_req(REQ_BOUNDED, 7'd0, 32'd10, $urandom(), $urandom());
	endtask

	task automatic test_random_traffic();
		logic [7:0] periods [6];
		periods = '{mwcrbg_pkg::PERIOD_RESET, 8'd16, 8'd1, 8'd255, 8'd0, 8'd0};
		periods[5] = 8'($urandom_range(255, 2));
		for (int p = 0; p < 6; p++) begin
			write_period(periods[p]);
			steady_flow = (p == 1);
			repeat (RANDOM_ITEMS / 6) send_random_req();
		end
		steady_flow = 1'b0;
	endtask

	always @(negedge clk)
		out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		rng_word_t head;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$error("unexpected word: data %h last %b", data, last);
				fail_count++;
			end else begin
				head = pending_words.pop_front();
				n_words++;
				if (data !== head.data) begin
					$error("data mismatch: expected %h, actual %h", head.data, data);
					fail_count++;
				end
				if (last !== head.last) begin
					$error("last mismatch: expected %b, actual %b", head.last, last);
					fail_count++;
				end
			end
		end
	end

	// no word moving on either side for too long means the block is hung
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles without a transfer", stall_cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		z_word = '0;
		w_word = '0;
		req_count = '0;
		period_reg = mwcrbg_pkg::PERIOD_RESET;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_byte_runs();
		test_bounded_words();
		test_reseed_period();
		test_random_traffic();
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (pending_words.size() != 0) begin
			$error("%0d words never arrived", pending_words.size());
			fail_count++;
		end
		$display("covered %0d requests (%0d bounded), %0d words checked, %0d reseeds",
			n_requests, n_bounded, n_words, n_reseeds);
		$display("%0d reseed period settings incl. 0, 1, 255 and a drop below the counter",
			n_periods);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
